@@ hdl/crcdf_pkg.sv @@
// ----------------------------------------------------------------------------
// crcdf_pkg
// Types, constants and the CRC-16 byte update shared by the frame deframer.
// ----------------------------------------------------------------------------
package crcdf_pkg;

   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_TOP        = 16'h8000;
   localparam logic [15:0] POLY_RESET     = 16'h1021;
   localparam logic [8:0]  COUNT_MAX      = 9'd511;
   localparam logic [8:0]  MIN_FRAME      = 9'd4;

   localparam logic [1:0]  STATUS_OK        = 2'd0;
   localparam logic [1:0]  STATUS_SHORT     = 2'd1;
   localparam logic [1:0]  STATUS_LEN_ERR   = 2'd2;
   localparam logic [1:0]  STATUS_CRC_ERR   = 2'd3;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic       is_status;
      logic [7:0] data_byte;
      logic [7:0] packet_id;
      logic [7:0] payload_length;
      logic [1:0] status;
   } rsp_type;

   // MSB-first CRC-16 over one byte, eight unrolled shift steps
   function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                            input logic [7:0]  data,
                                            input logic [15:0] poly);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ poly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ hdl/crc16_packet_deframer.sv @@
// ----------------------------------------------------------------------------
// crc16_packet_deframer
// Streaming frame checker: [LEN][ID][payload][CRC hi][CRC lo], CRC-16 MSB first.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one received byte per item, frame_end set on the last byte.
//   rsp_* returns one item per payload byte (is_status = 0) and one status
//   item on the final byte (id, LEN-2, status code). Header and CRC bytes
//   give no item. csr_wr_en/csr_wr_data load the CRC polynomial; write it
//   only while no frame byte is in flight.
// Timing:
//   An item is captured into the input register, evaluated in one pass
//   (8-step unrolled CRC byte update plus length compare) and loaded into
//   the result register, which drives rsp_valid and rsp_data.
//   Throughput is one item per cycle while the result register is not stalled.
// Stalls: when rsp_ready is low the result register holds; one more item
//   waits in the input register and req_ready then drops.
// Reset: clears the valid bits of both registers and the frame state;
//   polynomial returns to 0x1021.
// ----------------------------------------------------------------------------
module crc16_packet_deframer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  crcdf_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output crcdf_pkg::rsp_type rsp_data,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);

   logic               in_valid_ff;
   crcdf_pkg::req_type in_item_ff;
   logic               out_valid_ff;
   crcdf_pkg::rsp_type out_item_ff;
   logic [15:0]        poly_ff;

   logic               advance;
   logic               has_result;
   crcdf_pkg::rsp_type result;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   crcdf_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .item       (in_item_ff),
      .poly       (poly_ff),
      .result     (result),
      .has_result (has_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         poly_ff      <= crcdf_pkg::POLY_RESET;
      end else begin
         if (csr_wr_en) begin
            poly_ff <= csr_wr_data;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= has_result;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
      if (advance && has_result) begin
         out_item_ff <= result;
      end
   end

   a_ready_low_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && out_valid_ff && !rsp_ready)
      else $error("input stalled without a blocked result");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      advance && has_result |=> rsp_valid)
      else $error("result lost");

   a_status_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_status |-> rsp_data.data_byte == 8'd0)
      else $error("status item carries data byte");

   a_payload_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_status
      |-> rsp_data.status == crcdf_pkg::STATUS_OK && rsp_data.packet_id == 8'd0
          && rsp_data.payload_length == 8'd0)
      else $error("payload item carries status fields");

endmodule

@@ hdl/crcdf_frame.sv @@
// ----------------------------------------------------------------------------
// crcdf_frame
// Per-frame state and single-pass byte evaluation: CRC, length and status.
// ----------------------------------------------------------------------------
module crcdf_frame (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  crcdf_pkg::req_type item,
   input  logic [15:0]        poly,
   output crcdf_pkg::rsp_type result,
   output logic               has_result
);

   logic [8:0]  byte_count_ff,   byte_count_in;
   logic [7:0]  length_field_ff, length_field_in;
   logic [7:0]  frame_id_ff,     frame_id_in;
   logic [15:0] running_crc_ff,  running_crc_in;
   logic [15:0] received_crc_ff, received_crc_in;

   logic [8:0]  len_ext;
   logic [8:0]  count;
   logic [8:0]  len_plus2;
   logic        in_crc;

   always_comb begin
      length_field_in = (byte_count_ff == 9'd0) ? item.rx_byte : length_field_ff;
      frame_id_in     = (byte_count_ff == 9'd1) ? item.rx_byte : frame_id_ff;
      len_ext         = {1'b0, length_field_in};
      len_plus2       = len_ext + 9'd2;
      in_crc          = byte_count_ff < len_ext;
      running_crc_in  = in_crc ? crcdf_pkg::crc_byte(running_crc_ff, item.rx_byte, poly)
                               : running_crc_ff;
      received_crc_in = {received_crc_ff[7:0], item.rx_byte};
      count           = (byte_count_ff < crcdf_pkg::COUNT_MAX) ? byte_count_ff + 9'd1
                                                               : crcdf_pkg::COUNT_MAX;
      byte_count_in   = count;

      result     = '0;
      has_result = 1'b0;
      if (item.frame_end) begin
         has_result       = 1'b1;
         result.is_status = 1'b1;
         result.packet_id = frame_id_in;
         result.payload_length = (length_field_in >= 8'd2) ? length_field_in - 8'd2 : 8'd0;
         if (count < crcdf_pkg::MIN_FRAME) begin
            result.status = crcdf_pkg::STATUS_SHORT;
         end else if (count != len_plus2) begin
            result.status = crcdf_pkg::STATUS_LEN_ERR;
         end else if (running_crc_in != received_crc_in) begin
            result.status = crcdf_pkg::STATUS_CRC_ERR;
         end else begin
            result.status = crcdf_pkg::STATUS_OK;
         end
      end else if (byte_count_ff >= 9'd2 && in_crc) begin
         has_result       = 1'b1;
         result.data_byte = item.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff   <= '0;
         length_field_ff <= '0;
         frame_id_ff     <= '0;
         running_crc_ff  <= crcdf_pkg::CRC_INIT;
         received_crc_ff <= '0;
      end else if (step) begin
         if (item.frame_end) begin
            byte_count_ff   <= '0;
            length_field_ff <= '0;
            frame_id_ff     <= '0;
            running_crc_ff  <= crcdf_pkg::CRC_INIT;
            received_crc_ff <= '0;
         end else begin
            byte_count_ff   <= byte_count_in;
            length_field_ff <= length_field_in;
            frame_id_ff     <= frame_id_in;
            running_crc_ff  <= running_crc_in;
            received_crc_ff <= received_crc_in;
         end
      end
   end

   a_short_count: assert property (@(posedge clock) disable iff (reset)
      step && item.frame_end && count < crcdf_pkg::MIN_FRAME
      |-> result.status == crcdf_pkg::STATUS_SHORT)
      else $error("short frame not flagged");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      step && item.frame_end |=> byte_count_ff == 9'd0 && running_crc_ff == crcdf_pkg::CRC_INIT)
      else $error("frame state not cleared after final byte");

   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      step && !item.frame_end && byte_count_ff == crcdf_pkg::COUNT_MAX
      |=> byte_count_ff == crcdf_pkg::COUNT_MAX)
      else $error("byte counter wrapped");

endmodule
